// File: rtl/isc_pkg.sv
// isc_pkg: shared types, constants and the modular add for the increasing
// subsequence counter; used by isc_walk, isc_row and the top level
`default_nettype none

package isc_pkg;

  localparam int COUNT_W = 23;
  localparam int VALUE_W = 11;
  localparam int LEN_W   = 4;

  localparam int MAX_VALUE_DEF = 1024;
  localparam int MAX_LEN_DEF   = 8;

  localparam logic [COUNT_W-1:0] COUNT_MOD = COUNT_W'(5000000);
  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(2);

  // per-cycle commands from the walk sequencer to the row memories
  typedef struct packed {
    logic rd_en;
    logic acc_clr;
    logic acc_en;
    logic wr_upd;
    logic wr_clr;
    logic done;
    logic done_last;
  } isc_ctl_t;

  // a and b are both below the modulus
  function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, COUNT_MOD}) begin
      s = s - {1'b0, COUNT_MOD};
    end
    return s[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/isc_row.sv
// isc_row: one length row of the count table, kept as a binary indexed tree
// in a simple dual-port memory, with the prefix accumulator; uses isc_pkg
`default_nettype none

module isc_row #(
  parameter int MAX_VALUE = isc_pkg::MAX_VALUE_DEF
) (
  input  wire                              clk,
  input  wire isc_pkg::isc_ctl_t           ctl,
  input  wire [$clog2(MAX_VALUE)-1:0]      rd_addr,
  input  wire [$clog2(MAX_VALUE)-1:0]      wr_addr,
  input  wire                              active,
  input  wire [isc_pkg::COUNT_W-1:0]       add_val,
  output logic [isc_pkg::COUNT_W-1:0]      acc
);

  logic [isc_pkg::COUNT_W-1:0] mem [MAX_VALUE];
  logic [isc_pkg::COUNT_W-1:0] rd_data_r;
  logic [isc_pkg::COUNT_W-1:0] acc_r;
  logic [isc_pkg::COUNT_W-1:0] acc_nxt;
  logic [isc_pkg::COUNT_W-1:0] wr_data;
  logic                        wr_en;

  assign wr_en   = ctl.wr_clr || (ctl.wr_upd && active);
  assign wr_data = ctl.wr_clr ? '0 : isc_pkg::add_mod(rd_data_r, add_val);

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // prefix sum over the tree nodes read during the query walk
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctl.acc_en) begin
      acc_nxt = isc_pkg::add_mod(acc_r, rd_data_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// File: rtl/isc_walk.sv
// isc_walk: sequencer for the tree walks shared by all rows (clear sweep,
// prefix query, point update) and the input handshake; uses isc_pkg
`default_nettype none

module isc_walk #(
  parameter int MAX_VALUE = isc_pkg::MAX_VALUE_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [isc_pkg::VALUE_W-1:0]       in_value,
  input  wire                              in_is_last,
  input  wire                              out_free,
  output isc_pkg::isc_ctl_t                ctl,
  output logic [$clog2(MAX_VALUE)-1:0]     rd_addr,
  output logic [$clog2(MAX_VALUE)-1:0]     wr_addr
);

  localparam int AW = $clog2(MAX_VALUE);
  localparam int IW = $clog2(MAX_VALUE + 1);

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_QUERY, ST_UPD, ST_FIN} state_t;

  state_t        state_r, state_nxt;
  logic [IW:0]   idx_r, idx_nxt;
  logic [IW-1:0] v_r, v_nxt;
  logic          last_r, last_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          q_vld_r, q_vld_nxt;
  logic          u_vld_r, u_vld_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;

  logic [IW:0]   lowbit;
  logic [IW-1:0] v_sat;

  assign lowbit  = idx_r & (~idx_r + (IW+1)'(1));
  assign rd_addr = AW'(idx_r - (IW+1)'(1));
  assign wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : wr_addr_r;
  assign in_stall = (state_r != ST_IDLE);

  // out-of-range values saturate into 1..MAX_VALUE
  always_comb begin
    if (in_value == '0) begin
      v_sat = IW'(1);
    end else if (int'(in_value) > MAX_VALUE) begin
      v_sat = IW'(MAX_VALUE);
    end else begin
      v_sat = IW'(in_value);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    v_nxt        = v_r;
    last_nxt     = last_r;
    clr_addr_nxt = clr_addr_r;
    wr_addr_nxt  = wr_addr_r;
    q_vld_nxt    = 1'b0;
    u_vld_nxt    = 1'b0;

    ctl           = '0;
    ctl.acc_en    = q_vld_r;
    ctl.wr_upd    = u_vld_r;
    ctl.wr_clr    = (state_r == ST_CLEAR);

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_VALUE - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          v_nxt       = v_sat;
          last_nxt    = in_is_last;
          idx_nxt     = {1'b0, v_sat} - (IW+1)'(1);
          ctl.acc_clr = 1'b1;
          state_nxt   = ST_QUERY;
        end
      end
      ST_QUERY: begin
        // sum of nodes covering 1..v-1
        if (idx_r != '0) begin
          ctl.rd_en = 1'b1;
          q_vld_nxt = 1'b1;
          idx_nxt   = idx_r - lowbit;
        end else begin
          idx_nxt   = {1'b0, v_r};
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // read node now, write it back in the next cycle
        if (idx_r <= (IW+1)'(MAX_VALUE)) begin
          ctl.rd_en   = 1'b1;
          u_vld_nxt   = 1'b1;
          wr_addr_nxt = rd_addr;
          idx_nxt     = idx_r + lowbit;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_r || out_free) begin
          ctl.done      = 1'b1;
          ctl.done_last = last_r;
          state_nxt     = last_r ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      q_vld_r    <= 1'b0;
      u_vld_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      q_vld_r    <= q_vld_nxt;
      u_vld_r    <= u_vld_nxt;
    end
    idx_r     <= idx_nxt;
    v_r       <= v_nxt;
    last_r    <= last_nxt;
    wr_addr_r <= wr_addr_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/increasing_subsequence_counter_top.sv
// increasing_subsequence_counter_top: counts strictly increasing subsequences
// of a programmable length, modulo 5000000; uses isc_pkg, isc_walk, isc_row
`default_nettype none

// Each value of a sequence arrives as one request (in_value, in_is_last). The
// block keeps one binary indexed tree per subsequence length, each in its own
// memory row, so the count of length-j subsequences ending below v is a prefix
// sum over row j-1. All rows walk the same tree indices in lockstep: first a
// prefix query at v-1 (one read per set bit of v-1), then a read-modify-write
// update from v upward (one read per step, write-back in the next cycle). For a
// power-of-two MAX_VALUE the two walks always add up to log2(MAX_VALUE) + 1
// steps; both walks go through the single read port of each row memory, and a
// new request is taken only once the last one is through. On the request
// flagged last the total is handed to the output register (the block waits
// there only if an earlier result is still not taken) and the table is swept
// to zero, one address of every row per cycle, also after reset, during which
// in_stall stays high. cfg_wr_data sets the length (0 acts as 1, above MAX_LEN
// as MAX_LEN); write it only while the block is idle.
module increasing_subsequence_counter_top #(
  parameter int MAX_VALUE = isc_pkg::MAX_VALUE_DEF,
  parameter int MAX_LEN   = isc_pkg::MAX_LEN_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // configuration
  input  wire                          cfg_wr_en,
  input  wire [isc_pkg::LEN_W-1:0]     cfg_wr_data,
  // value requests
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire [isc_pkg::VALUE_W-1:0]   in_value,
  input  wire                          in_is_last,
  // count results
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [isc_pkg::COUNT_W-1:0]  out_subseq_count
);

  localparam int AW  = $clog2(MAX_VALUE);
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int LIW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // configuration register
  logic [isc_pkg::LEN_W-1:0] subseq_length_r;
  logic [LW-1:0]             len_eff;
  logic [LW-1:0]             len_m1;

  // walk control shared by all rows
  isc_pkg::isc_ctl_t ctl;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              out_free;

  // per-row data
  logic [isc_pkg::COUNT_W-1:0] acc_w [MAX_LEN];
  logic [isc_pkg::COUNT_W-1:0] cur_w [MAX_LEN];
  logic [MAX_LEN-1:0]          active_w;
  logic [isc_pkg::COUNT_W-1:0] cur_sel;

  // running total and result register
  logic [isc_pkg::COUNT_W-1:0] total_r, total_nxt;
  logic [isc_pkg::COUNT_W-1:0] sum_w;
  logic                        out_valid_r, out_valid_nxt;
  logic [isc_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subseq_length_r <= isc_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      subseq_length_r <= cfg_wr_data;
    end
  end

  // saturate the programmed length into 1..MAX_LEN
  always_comb begin
    if (subseq_length_r == '0) begin
      len_eff = LW'(1);
    end else if (int'(subseq_length_r) > MAX_LEN) begin
      len_eff = LW'(MAX_LEN);
    end else begin
      len_eff = LW'(subseq_length_r);
    end
  end

  assign len_m1 = len_eff - LW'(1);

  // the result register can take a new count this cycle
  assign out_free = !out_valid_r || !out_stall;

  isc_walk #(
    .MAX_VALUE (MAX_VALUE)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .in_is_last (in_is_last),
    .out_free   (out_free),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr)
  );

  // row j counts subsequences of length j+1; it adds one for length one,
  // otherwise the prefix sum that row j-1 just gathered
  for (genvar j = 0; j < MAX_LEN; j++) begin : g_row
    if (j == 0) begin : g_first
      assign cur_w[j] = isc_pkg::COUNT_W'(1);
    end else begin : g_next
      assign cur_w[j] = acc_w[j-1];
    end

    // rows past the current length are not updated, only cleared by the sweep
    assign active_w[j] = (LW'(j) < len_eff);

    isc_row #(
      .MAX_VALUE (MAX_VALUE)
    ) u_row (
      .clk     (clk),
      .ctl     (ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .active  (active_w[j]),
      .add_val (cur_w[j]),
      .acc     (acc_w[j])
    );
  end

  // count of full-length subsequences ending at this value
  assign cur_sel = cur_w[len_m1[LIW-1:0]];
  assign sum_w   = isc_pkg::add_mod(total_r, cur_sel);

  always_comb begin
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.done) begin
      if (ctl.done_last) begin
        total_nxt     = '0;
        out_valid_nxt = 1'b1;
        out_count_nxt = sum_w;
      end else begin
        total_nxt = sum_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_count_r <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_subseq_count = out_count_r;

endmodule

`default_nettype wire
